// ----- hw/rtl/egbr_pkg.sv -----
package egbr_pkg;

    // request codes as they arrive on the input item
    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_RAW  = 2'd1,
        OP_UE   = 2'd2,
        OP_SE   = 2'd3
    } t_op;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_LONG  = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // raw reads are capped at this many bits
    localparam logic [5:0] RAW_MAX = 6'd32;

    // classified command handed from front to back
    typedef struct packed {
        t_op         op;
        logic [31:0] word;
        logic [5:0]  cnt;
    } t_cmd;

    // one result item
    typedef struct packed {
        logic [31:0] uval;
        logic [31:0] sval;
        logic [1:0]  status;
        logic [6:0]  avail;
        logic [31:0] total;
    } t_res;

endpackage

// ----- hw/rtl/egbr_fifo.sv -----
module egbr_fifo import egbr_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    // two-entry queue, head shown directly
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wp <= ~r_wp;
            end
            if (rd_en) begin
                r_rp <= ~r_rp;
            end
            case ({wr_en, rd_en})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- hw/rtl/egbr_front.sv -----
module egbr_front import egbr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [1:0]  i_req_type,
    input  logic [31:0] i_stream_word,
    input  logic [5:0]  i_bit_count,
    output logic        o_cmd_valid,
    output t_cmd        o_cmd,
    input  logic        i_cmd_full
);

    logic r_vld;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic take;
    logic drain;

    // the stage drains into the command queue whenever it has room
    assign drain       = r_vld && !i_cmd_full;
    assign o_full      = r_vld && i_cmd_full;
    assign take        = i_push && !o_full;
    assign o_cmd_valid = drain;
    assign o_cmd       = r_cmd;

    // classify: decode the request, saturate the raw count
    always_comb begin
        n_cmd.op   = t_op'(i_req_type);
        n_cmd.word = i_stream_word;
        n_cmd.cnt  = (i_bit_count > RAW_MAX) ? RAW_MAX : i_bit_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (take) begin
            r_vld <= 1'b1;
        end else if (drain) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ----- hw/rtl/egbr_back.sv -----
module egbr_back import egbr_pkg::*; #(
    parameter int WORD_BITS   = 32,
    parameter int BUFFER_BITS = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    input  t_cmd i_cmd,
    output logic o_cmd_pop,
    output logic o_res_push,
    output t_res o_res,
    input  logic i_res_full
);

    localparam int FW = $clog2(BUFFER_BITS + 1);

    // bit window: oldest bit at the MSB, bits past the fill level are zero
    logic [BUFFER_BITS-1:0] r_buf;
    logic [FW-1:0]          r_fill;
    logic [31:0]            r_total;
    logic [BUFFER_BITS-1:0] n_buf;
    logic [FW-1:0]          n_fill;
    logic [31:0]            n_total;

    logic                   go;
    logic [31:0]            top32;
    logic [63:0]            top64;
    logic [5:0]             lz;
    logic [5:0]             len;
    logic [63:0]            code_full;
    logic [31:0]            code;
    logic [31:0]            half;
    logic [FW:0]            load_sum;
    logic [BUFFER_BITS-1:0] placed;
    logic [5:0]             used;
    logic                   ok;
    logic [31:0]            uval;
    logic [31:0]            sval;
    logic [1:0]             status;

    // leading zeros of a 32-bit word by halving
    function automatic logic [5:0] lzc32(input logic [31:0] x);
        logic [31:0] v;
        logic [5:0]  n;
        v = x;
        n = 6'd0;
        if (v[31:16] == 16'd0) begin n = n + 6'd16; v = v << 16; end
        if (v[31:24] == 8'd0)  begin n = n + 6'd8;  v = v << 8;  end
        if (v[31:28] == 4'd0)  begin n = n + 6'd4;  v = v << 4;  end
        if (v[31:30] == 2'd0)  begin n = n + 6'd2;  v = v << 2;  end
        if (v[31] == 1'b0)     begin n = n + 6'd1;  v = v << 1;  end
        if (v[31] == 1'b0)     begin n = n + 6'd1;               end
        return n;
    endfunction

    assign go         = i_cmd_valid && !i_res_full;
    assign o_cmd_pop  = go;
    assign o_res_push = go;

    // window views shared by all requests
    assign top32     = r_buf[BUFFER_BITS-1 -: 32];
    assign top64     = r_buf[BUFFER_BITS-1 -: 64];
    assign lz        = lzc32(top32);
    assign len       = {lz[4:0], 1'b1};
    assign code_full = top64 >> (7'd64 - {1'b0, len});
    assign code      = code_full[31:0] - 32'd1;
    assign half      = code >> 1;
    assign load_sum  = {1'b0, r_fill} + (FW+1)'(WORD_BITS);
    assign placed    = {i_cmd.word[WORD_BITS-1:0], {(BUFFER_BITS-WORD_BITS){1'b0}}} >> r_fill;

    // execute one command
    always_comb begin
        uval   = 32'd0;
        sval   = 32'd0;
        status = ST_OK;
        used   = 6'd0;
        ok     = 1'b0;
        n_buf  = r_buf;
        case (i_cmd.op)
            OP_LOAD: begin
                if (load_sum > (FW+1)'(BUFFER_BITS)) begin
                    status = ST_FULL;
                end else begin
                    n_buf = r_buf | placed;
                end
            end
            OP_RAW: begin
                if (FW'(i_cmd.cnt) > r_fill) begin
                    status = ST_SHORT;
                end else begin
                    uval = top32 >> (6'd32 - i_cmd.cnt);
                    used = i_cmd.cnt;
                    ok   = 1'b1;
                end
            end
            OP_UE, OP_SE: begin
                if (r_fill >= FW'(32)) begin
                    if (lz == 6'd32) begin
                        status = ST_LONG;
                    end else if (FW'(len) > r_fill) begin
                        status = ST_SHORT;
                    end else begin
                        ok = 1'b1;
                    end
                end else if (FW'(lz) >= r_fill) begin
                    status = ST_SHORT;
                end else if (FW'(len) > r_fill) begin
                    status = ST_SHORT;
                end else begin
                    ok = 1'b1;
                end
                if (ok) begin
                    used = len;
                    uval = code;
                    if (i_cmd.op == OP_SE) begin
                        sval = code[0] ? (half + 32'd1) : (32'd0 - half);
                    end
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
        if (ok) begin
            n_buf = r_buf << used;
        end
    end

    assign n_fill  = (i_cmd.op == OP_LOAD) ?
                     ((status == ST_OK) ? load_sum[FW-1:0] : r_fill) :
                     (r_fill - FW'(used));
    assign n_total = r_total + 32'(used);

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf   <= '0;
            r_fill  <= '0;
            r_total <= 32'd0;
        end else if (go) begin
            r_buf   <= n_buf;
            r_fill  <= n_fill;
            r_total <= n_total;
        end
    end

    // result item
    always_comb begin
        o_res.uval   = uval;
        o_res.sval   = sval;
        o_res.status = status;
        o_res.avail  = n_fill[6:0];
        o_res.total  = n_total;
    end

endmodule

// ----- hw/rtl/exp_golomb_bit_reader_top.sv -----
// Exp-Golomb bit reader: MSB-first bitstream reader.
// Input queue port: push/full with i_req_type, i_stream_word, i_bit_count.
// An item loads a word (low WORD_BITS bits of i_stream_word), reads 0..32 raw
// bits, or decodes one unsigned or signed Exp-Golomb code.
// Result queue port: empty/pop; the oldest result sits on the o_ ports while
// empty is low and leaves on pop. Every item yields exactly one result.
// An accepted item passes the classify register, then the command queue;
// execute writes straight into the result queue, whose head is shown.
// Throughput: one item per cycle while the result queue has room; the execute
// stage updates the bit window, fill level and bit count at once (leading-zero
// count plus window shift), which sets that figure.
// Failed requests report a status and leave all state unchanged.
// Reset clears the bit window, fill level, running bit count and both queues.
// When the receiver stops popping, the two-entry result queue fills, then the
// execute stage stalls, then the command queue and classify register fill,
// and full rises; nothing is dropped.
module exp_golomb_bit_reader_top import egbr_pkg::*; #(
    parameter int WORD_BITS   = 32,
    parameter int BUFFER_BITS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         i_req_type,
    input  logic [31:0]        i_stream_word,
    input  logic [5:0]         i_bit_count,
    output logic               empty,
    input  logic               pop,
    output logic [31:0]        o_unsigned_value,
    output logic signed [31:0] o_signed_value,
    output logic [1:0]         o_status,
    output logic [6:0]         o_bits_available,
    output logic [31:0]        o_bits_read_total
);

    logic fr_valid;
    t_cmd fr_cmd;
    logic cq_full;
    logic cq_empty;
    t_cmd cq_cmd;
    logic cq_pop;
    logic rq_push;
    logic rq_full;
    t_res bk_res;
    t_res rq_res;

    // front: accept and classify
    egbr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_req_type   (i_req_type),
        .i_stream_word(i_stream_word),
        .i_bit_count  (i_bit_count),
        .o_cmd_valid  (fr_valid),
        .o_cmd        (fr_cmd),
        .i_cmd_full   (cq_full)
    );

    // command queue between front and back
    egbr_fifo #(.WIDTH($bits(t_cmd))) u_cmd_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (fr_valid),
        .i_data (fr_cmd),
        .o_full (cq_full),
        .i_pop  (cq_pop),
        .o_data (cq_cmd),
        .o_empty(cq_empty)
    );

    // back: bit window and decode
    egbr_back #(
        .WORD_BITS  (WORD_BITS),
        .BUFFER_BITS(BUFFER_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd_valid(!cq_empty),
        .i_cmd      (cq_cmd),
        .o_cmd_pop  (cq_pop),
        .o_res_push (rq_push),
        .o_res      (bk_res),
        .i_res_full (rq_full)
    );

    // result queue toward the receiver
    egbr_fifo #(.WIDTH($bits(t_res))) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (rq_push),
        .i_data (bk_res),
        .o_full (rq_full),
        .i_pop  (pop),
        .o_data (rq_res),
        .o_empty(empty)
    );

    assign o_unsigned_value  = rq_res.uval;
    assign o_signed_value    = $signed(rq_res.sval);
    assign o_status          = rq_res.status;
    assign o_bits_available  = rq_res.avail;
    assign o_bits_read_total = rq_res.total;

endmodule
